[rtl/vbc_pkg.sv]
`default_nettype none

package vbc_pkg;

    // Field and state widths
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 6;
    localparam int LETTER_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    // Key storage layout: twelve five-bit letters to a key word
    localparam int LETTERS_PER_WORD = 12;

    // Default key capacity
    localparam int DEF_MAX_KEY_LETTERS = 48;

    // Alphabet constants
    localparam logic [LETTER_W-1:0] ALPHABET_LEN  = 5'd26;
    localparam logic [CHAR_W-1:0]   CHAR_A        = 8'd65;
    localparam logic [CHAR_W-1:0]   CHAR_Z        = 8'd90;
    localparam logic [CHAR_W-1:0]   CHAR_SPACE    = 8'd32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUBTRACT_VARIANT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0       = 3'd3;

    // Mode settings handed from the register file to the cipher core
    typedef struct packed {
        logic [POS_W-1:0] key_len;   // effective key length, 1..capacity
        logic             decrypt;
        logic             subtract;
    } t_cfg;

    // One result byte with its end-of-run flag
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              run_last;
    } t_item;

    // Reduce a five-bit key letter into 0..25.
    function automatic logic [LETTER_W-1:0] f_fold_letter(input logic [LETTER_W-1:0] k);
        logic [LETTER_W-1:0] res;
        res = (k >= ALPHABET_LEN) ? (k - ALPHABET_LEN) : k;
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/vbc_cfg_regs.sv]
`default_nettype none

module vbc_cfg_regs #(
    parameter int MAX_KEY_LETTERS = vbc_pkg::DEF_MAX_KEY_LETTERS
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_wr_en,
    input  wire logic [vbc_pkg::CFG_IDX_W-1:0]                i_wr_index,
    input  wire logic [vbc_pkg::CFG_DATA_W-1:0]               i_wr_data,
    output      vbc_pkg::t_cfg                                o_cfg,
    output      logic [MAX_KEY_LETTERS-1:0][vbc_pkg::LETTER_W-1:0] o_key
);

    localparam logic [vbc_pkg::POS_W-1:0] MAX_LEN = vbc_pkg::POS_W'(MAX_KEY_LETTERS);

    logic [vbc_pkg::POS_W-1:0] r_len;
    logic [vbc_pkg::POS_W-1:0] n_len;
    logic                      r_decrypt;
    logic                      r_subtract;
    logic [MAX_KEY_LETTERS-1:0][vbc_pkg::LETTER_W-1:0] r_key;

    // Length is stored already clamped to 1..capacity.
    always_comb begin
        n_len = i_wr_data[vbc_pkg::POS_W-1:0];
        if (n_len == '0) begin
            n_len = vbc_pkg::POS_W'(1);
        end else if (n_len > MAX_LEN) begin
            n_len = MAX_LEN;
        end
    end

    // Mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= vbc_pkg::POS_W'(1);
            r_decrypt  <= 1'b0;
            r_subtract <= 1'b0;
        end else if (i_wr_en) begin
            if (i_wr_index == vbc_pkg::REG_KEY_LENGTH) begin
                r_len <= n_len;
            end
            if (i_wr_index == vbc_pkg::REG_DECRYPT_MODE) begin
                r_decrypt <= i_wr_data[0];
            end
            if (i_wr_index == vbc_pkg::REG_SUBTRACT_VARIANT) begin
                r_subtract <= i_wr_data[0];
            end
        end
    end

    // Key letters, each folded into 0..25 as it is written.
    for (genvar l = 0; l < MAX_KEY_LETTERS; l++) begin : g_key
        localparam int WORD = l / vbc_pkg::LETTERS_PER_WORD;
        localparam int OFFS = (l % vbc_pkg::LETTERS_PER_WORD) * vbc_pkg::LETTER_W;
        localparam logic [vbc_pkg::CFG_IDX_W-1:0] WORD_IDX =
            vbc_pkg::CFG_IDX_W'(int'(vbc_pkg::REG_KEY_WORD_0) + WORD);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_key[l] <= '0;
            end else if (i_wr_en && (i_wr_index == WORD_IDX)) begin
                r_key[l] <= vbc_pkg::f_fold_letter(i_wr_data[OFFS +: vbc_pkg::LETTER_W]);
            end
        end
    end

    assign o_cfg.key_len  = r_len;
    assign o_cfg.decrypt  = r_decrypt;
    assign o_cfg.subtract = r_subtract;
    assign o_key          = r_key;

endmodule

`default_nettype wire

[rtl/vbc_cipher_core.sv]
`default_nettype none

module vbc_cipher_core #(
    parameter int MAX_KEY_LETTERS = vbc_pkg::DEF_MAX_KEY_LETTERS
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_accept,
    input  wire logic [vbc_pkg::CHAR_W-1:0]                   i_char,
    input  wire logic                                         i_msg_end,
    input       vbc_pkg::t_cfg                                i_cfg,
    input  wire logic [MAX_KEY_LETTERS-1:0][vbc_pkg::LETTER_W-1:0] i_key,
    output      logic [1:0]                                   o_push_cnt,
    output      vbc_pkg::t_item                               o_item0,
    output      vbc_pkg::t_item                               o_item1
);

    localparam int KEY_IDX_W = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;

    logic [vbc_pkg::POS_W-1:0]    r_pos;
    logic [vbc_pkg::POS_W-1:0]    n_pos;
    logic [vbc_pkg::POS_W-1:0]    pos_eff;
    logic [vbc_pkg::POS_W-1:0]    pos_inc;
    logic                         is_letter;
    logic                         is_space;
    logic                         group_done;
    logic                         use_sub;
    logic [vbc_pkg::LETTER_W-1:0] plain_idx;
    logic [vbc_pkg::LETTER_W-1:0] key_letter;
    logic [vbc_pkg::LETTER_W:0]   sum;
    logic [vbc_pkg::LETTER_W:0]   sum_mod;
    logic [vbc_pkg::CHAR_W-1:0]   letter_out;

    // A position left past a shortened key restarts at the first letter.
    assign pos_eff = (r_pos >= i_cfg.key_len) ? '0 : r_pos;
    assign pos_inc = pos_eff + vbc_pkg::POS_W'(1);

    assign is_letter  = (i_char >= vbc_pkg::CHAR_A) && (i_char <= vbc_pkg::CHAR_Z);
    assign is_space   = (i_char == vbc_pkg::CHAR_SPACE);
    assign group_done = (pos_inc >= i_cfg.key_len);
    assign use_sub    = i_cfg.subtract ^ i_cfg.decrypt;

    // Letter arithmetic modulo 26
    assign plain_idx  = vbc_pkg::LETTER_W'(i_char - vbc_pkg::CHAR_A);
    assign key_letter = i_key[pos_eff[KEY_IDX_W-1:0]];

    always_comb begin
        if (use_sub) begin
            sum = {1'b0, plain_idx} + {1'b0, vbc_pkg::ALPHABET_LEN} - {1'b0, key_letter};
        end else begin
            sum = {1'b0, plain_idx} + {1'b0, key_letter};
        end
        sum_mod = (sum >= {1'b0, vbc_pkg::ALPHABET_LEN}) ?
                  (sum - {1'b0, vbc_pkg::ALPHABET_LEN}) : sum;
    end

    assign letter_out = vbc_pkg::CHAR_A + vbc_pkg::CHAR_W'(sum_mod);

    // Results caused by this byte and the next key position
    always_comb begin
        o_item0.out_char = i_char;
        o_item0.run_last = 1'b1;
        o_item1.out_char = vbc_pkg::CHAR_SPACE;
        o_item1.run_last = 1'b1;
        o_push_cnt       = 2'd1;
        n_pos            = pos_eff;
        if (is_letter) begin
            o_item0.out_char = letter_out;
            n_pos            = group_done ? '0 : pos_inc;
            if (group_done && !i_cfg.decrypt) begin
                o_item0.run_last = 1'b0;
                o_push_cnt       = 2'd2;
            end
        end else if (is_space && i_cfg.decrypt) begin
            o_push_cnt = 2'd0;
        end
        if (i_msg_end) begin
            n_pos = '0;
        end
    end

    // Key position register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

[rtl/vbc_out_queue.sv]
`default_nettype none

module vbc_out_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [1:0]     i_push_cnt,
    input       vbc_pkg::t_item i_item0,
    input       vbc_pkg::t_item i_item1,
    output      logic           o_room,
    output      logic           o_valid,
    input  wire logic           i_ready,
    output      vbc_pkg::t_item o_item
);

    // Three slots: one being offered plus room for a letter and its group space.
    localparam int DEPTH = 3;

    vbc_pkg::t_item r_q [DEPTH];
    vbc_pkg::t_item n_q [DEPTH];
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic [1:0]     cnt_pop;
    logic           pop;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign cnt_pop = pop ? (r_cnt - 2'd1) : r_cnt;

    // Shift out the head on a taken request, then append the new results.
    always_comb begin
        n_q = r_q;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        n_cnt = cnt_pop + i_push_cnt;
        case (i_push_cnt)
            2'd1: begin
                n_q[cnt_pop] = i_item0;
            end
            2'd2: begin
                n_q[cnt_pop]         = i_item0;
                n_q[cnt_pop + 2'd1]  = i_item1;
            end
            default: begin
                n_cnt = cnt_pop;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_room  = (r_cnt <= 2'd1);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[0];

endmodule

`default_nettype wire

[rtl/vigenere_beaufort_stream_cipher.sv]
// Repeating-key letter cipher over a byte stream.
// Input stream: s_axis tdata carries one message byte, tlast marks the last
// byte of a message; the key position returns to the first letter after it.
// Output stream: m_axis tdata carries one result byte, tlast is set on the
// final result that an input byte causes.
// Configuration: cfg_valid/cfg_ready with a register index and data; writes
// are taken in every cycle and must only be made while the stream is idle.
// Results are registered in the output queue and offered from its head.
// Throughput: one byte per cycle while m_axis tready is high. On encrypt, a
// letter that closes a key group also yields a space, which holds s_axis
// tready low until the three-entry output queue has two free slots again.
// Reset: the key length returns to 1, modes and key letters to zero, the key
// position to the first letter, and the output queue empties.
// Stall: while the receiver holds tready low the queue keeps its results and
// s_axis tready drops once fewer than two slots are free.
`default_nettype none

module vigenere_beaufort_stream_cipher #(
    parameter int MAX_KEY_LETTERS = vbc_pkg::DEF_MAX_KEY_LETTERS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write channel
    input  wire logic                             i_cfg_valid,
    output      logic                             o_cfg_ready,
    input  wire logic [vbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [vbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input byte stream
    input  wire logic                             i_s_axis_tvalid,
    output      logic                             o_s_axis_tready,
    input  wire logic [vbc_pkg::CHAR_W-1:0]       i_s_axis_tdata,  // [7:0] in_char
    input  wire logic                             i_s_axis_tlast,  // message_end
    // Result byte stream
    output      logic                             o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output      logic [vbc_pkg::CHAR_W-1:0]       o_m_axis_tdata,  // [7:0] out_char
    output      logic                             o_m_axis_tlast   // run_last
);

    vbc_pkg::t_cfg  cfg;
    vbc_pkg::t_item item0;
    vbc_pkg::t_item item1;
    vbc_pkg::t_item head;
    logic [MAX_KEY_LETTERS-1:0][vbc_pkg::LETTER_W-1:0] key;
    logic [1:0]     push_cnt;
    logic           room;
    logic           accept;
    logic           cfg_wr;

    // Register writes never wait.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;

    vbc_cfg_regs #(
        .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (cfg_wr),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg),
        .o_key      (key)
    );

    vbc_cipher_core #(
        .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_char     (i_s_axis_tdata),
        .i_msg_end  (i_s_axis_tlast),
        .i_cfg      (cfg),
        .i_key      (key),
        .o_push_cnt (push_cnt),
        .o_item0    (item0),
        .o_item1    (item1)
    );

    vbc_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (accept ? push_cnt : 2'd0),
        .i_item0    (item0),
        .i_item1    (item1),
        .o_room     (room),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_item     (head)
    );

    assign o_m_axis_tdata = head.out_char;
    assign o_m_axis_tlast = head.run_last;

endmodule

`default_nettype wire
